// ----- rtl/gbfa_pkg.sv -----
// Package for the GB2312 text to font address block.
// Item types, queue command type, register indexes and byte code constants.
// No dependencies.
`timescale 1ns / 1ps

package gbfa_pkg;

  localparam int XW = 12;
  localparam int YW = 8;
  localparam int AW = 18;
  localparam int OFFW = 12;
  localparam int CFGW = 18;

  localparam logic [7:0] HANZI_LO  = 8'hB0;
  localparam logic [7:0] HANZI_HI  = 8'hF7;
  localparam logic [7:0] SYM_LO    = 8'hA1;
  localparam logic [7:0] SYM_HI    = 8'hA3;
  localparam logic [7:0] TRAIL_LO  = 8'hA1;
  localparam logic [7:0] ASCII_LO  = 8'h20;
  localparam logic [7:0] ASCII_HI  = 8'h7E;
  localparam logic [13:0] ROW_GLYPHS = 14'd94;
  localparam logic [XW-1:0] X_MAX = 12'd4095;
  localparam logic [XW:0] STEP_WIDE   = 13'd16;
  localparam logic [XW:0] STEP_NARROW = 13'd8;

  localparam logic [OFFW-1:0] HANZI_OFFSET_RESET = 12'd846;
  localparam logic [AW-1:0]   ASCII_BASE_RESET   = 18'h3B7C0;

  typedef enum logic {
    CFG_HANZI_INDEX_OFFSET = 1'b0,
    CFG_ASCII_BASE_ADDRESS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]    text_byte;
    logic          first_of_string;
    logic [XW-1:0] start_x;
    logic [YW-1:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic [AW-1:0] font_address;
    logic          glyph_wide;
    logic [XW-1:0] draw_x;
    logic [YW-1:0] draw_y;
  } out_item_t;

  // row: lead offset; col: trail offset (wide) or ascii offset (narrow)
  typedef struct packed {
    logic          wide;
    logic          hanzi;
    logic [6:0]    row;
    logic [6:0]    col;
    logic [XW-1:0] draw_x;
    logic [YW-1:0] draw_y;
  } glyph_cmd_t;

endpackage

// ----- rtl/gb2312_text_to_font_address_core.sv -----
// Top level of the GB2312 text to font address block.
// Instantiates gbfa_front, gbfa_queue and gbfa_back; depends on gbfa_pkg.
//
// Usage: text bytes enter on in_valid/in_stall with in_item; each item is
// one byte plus an optional start-of-string position. Every hanzi or symbol
// character (lead + trail byte) and every printable ASCII byte yields one
// glyph request on out_valid/out_stall with out_item: font ROM address,
// width flag and pixel position. Lead bytes, NUL and unmatched bytes yield
// nothing.
// Throughput: one byte per cycle while in_stall is low, set by the front
// part classifying one byte per cycle. The byte that completes a glyph is
// queued at the edge that accepts it; the command then loads the output
// register when popped and is held there until the receiver takes it.
// Two-entry command queue parts the front from the output register; when the
// receiver stalls, the queue fills and in_stall rises once it is full.
// Configuration is written through cfg_write_enable/cfg_index/cfg_data;
// the user must write it only while idle; the block does not enforce this.
// Reset (rst, synchronous) clears cursor, line, pending lead and queue,
// and loads the register reset values.
`timescale 1ns / 1ps

module gb2312_text_to_font_address_core
  import gbfa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic            cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  logic       accept, push, pop, q_full, q_not_empty;
  glyph_cmd_t push_cmd, head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  gbfa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .cmd    (push_cmd)
  );

  gbfa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  gbfa_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd_valid        (q_not_empty),
    .cmd              (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item)
  );

endmodule

// ----- rtl/gbfa_front.sv -----
// Front part: accepts text bytes, tracks the pending lead byte and cursor,
// and issues glyph commands. Depends on gbfa_pkg.
`timescale 1ns / 1ps

module gbfa_front
  import gbfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_item_t   item,
  output logic       push,
  output glyph_cmd_t cmd
);

  logic          pend_valid, pend_valid_next;
  logic          pend_hanzi, pend_hanzi_next;
  logic [6:0]    pend_row, pend_row_next;
  logic [XW-1:0] cursor_x, cursor_x_next;
  logic [YW-1:0] line_y, line_y_next;

  logic          eff_pv;
  logic [XW-1:0] cx;
  logic [YW-1:0] ly;
  logic [7:0]    b;
  logic          is_hz, is_sym, is_ascii, emit, wide;
  logic [XW:0]   adv;

  always_comb begin
    b        = item.text_byte;
    eff_pv   = pend_valid && !item.first_of_string;
    cx       = item.first_of_string ? item.start_x : cursor_x;
    ly       = item.first_of_string ? item.start_y : line_y;
    is_hz    = (b >= HANZI_LO) && (b <= HANZI_HI);
    is_sym   = (b >= SYM_LO) && (b <= SYM_HI);
    is_ascii = (b >= ASCII_LO) && (b <= ASCII_HI);

    pend_valid_next = 1'b0;
    pend_hanzi_next = pend_hanzi;
    pend_row_next   = pend_row;
    emit = 1'b0;
    wide = 1'b0;
    cmd.hanzi = pend_hanzi;
    cmd.row   = pend_row;
    cmd.col   = 7'(b - ASCII_LO);

    if (eff_pv && (b >= TRAIL_LO)) begin
      emit    = 1'b1;
      wide    = 1'b1;
      cmd.col = 7'(b - TRAIL_LO);
    end else if (is_hz || is_sym) begin
      pend_valid_next = 1'b1;
      pend_hanzi_next = is_hz;
      pend_row_next   = is_hz ? 7'(b - HANZI_LO) : 7'(b - SYM_LO);
    end else if (is_ascii) begin
      emit = 1'b1;
    end

    cmd.wide   = wide;
    cmd.draw_x = cx;
    cmd.draw_y = ly;
    push       = accept && emit;

    adv = {1'b0, cx} + (wide ? STEP_WIDE : STEP_NARROW);
    if (emit) begin
      cursor_x_next = adv[XW] ? X_MAX : adv[XW-1:0];
    end else begin
      cursor_x_next = cx;
    end
    line_y_next = ly;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_hanzi <= 1'b0;
      pend_row   <= '0;
      cursor_x   <= '0;
      line_y     <= '0;
    end else if (accept) begin
      pend_valid <= pend_valid_next;
      pend_hanzi <= pend_hanzi_next;
      pend_row   <= pend_row_next;
      cursor_x   <= cursor_x_next;
      line_y     <= line_y_next;
    end
  end

endmodule

// ----- rtl/gbfa_queue.sv -----
// Two-entry command queue between front and back parts.
// Depends on gbfa_pkg.
`timescale 1ns / 1ps

module gbfa_queue
  import gbfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  glyph_cmd_t push_cmd,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output glyph_cmd_t head
);

  glyph_cmd_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;

  always_comb begin
    full       = (count == 2'd2);
    not_empty  = (count != 2'd0);
    head       = entry[rd_ptr];
    count_next = count + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

// ----- rtl/gbfa_back.sv -----
// Back part: holds the configuration registers, turns glyph commands into
// font ROM addresses and drives the output register. Depends on gbfa_pkg.
`timescale 1ns / 1ps

module gbfa_back
  import gbfa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic            cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic            cmd_valid,
  input  glyph_cmd_t      cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  logic [OFFW-1:0] hanzi_index_offset;
  logic [AW-1:0]   ascii_base_address;
  logic [13:0]     prod, idx;
  logic [AW-1:0]   addr;

  always_comb begin
    prod = 14'(cmd.row) * ROW_GLYPHS;
    idx  = prod + 14'(cmd.col) + (cmd.hanzi ? 14'(hanzi_index_offset) : 14'd0);
    if (cmd.wide) begin
      addr = {idx[12:0], 5'b0};
    end else begin
      addr = {7'd0, cmd.col, 4'b0} + ascii_base_address;
    end
    pop = cmd_valid && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hanzi_index_offset <= HANZI_OFFSET_RESET;
      ascii_base_address <= ASCII_BASE_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HANZI_INDEX_OFFSET: hanzi_index_offset <= cfg_data[OFFW-1:0];
        CFG_ASCII_BASE_ADDRESS: ascii_base_address <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.font_address <= addr;
      out_item.glyph_wide   <= cmd.wide;
      out_item.draw_x       <= cmd.draw_x;
      out_item.draw_y       <= cmd.draw_y;
    end
  end

endmodule
